// ===== sv/ehct_pkg.sv =====
// Package for the edge hit count table: sizes, function codes, FSM states,
// and the command and status structs between controller and datapath. No dependencies.
`default_nettype none
package ehct_pkg;
	localparam int unsigned ENTRIES_DEF     = 1024;
	localparam int unsigned HASH_SLOTS_DEF  = 2048;
	localparam int unsigned COUNT_WIDTH_DEF = 32;
	localparam int unsigned ADDR_W          = 64;
	localparam int unsigned SLOT_OUT_W      = 10;
	localparam int unsigned TOTAL_OUT_W     = 11;
	localparam int unsigned HIT_OUT_W       = 32;

	typedef enum logic [1:0] {
		FUNC_RECORD = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HASH,
		ST_PROBE,
		ST_FETCH,
		ST_PCMP,
		ST_UPDATE,
		ST_INSERT,
		ST_READ,
		ST_RDOUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;       // capture the input word
		logic hash;       // compute start position
		logic probe_rd;   // read hash memory at probe position
		logic entry_rd;   // read pair and count memories at pointer
		logic step;       // advance probe position
		logic do_hit;     // write incremented count, build hit result
		logic do_insert;  // append the pair, build insert result
		logic do_drop;    // build drop result
		logic slot_rd;    // read ordered slot for a read word
		logic do_read;    // build read result
		logic do_misc;    // build clear or unused result
		logic clr_step;   // clear one hash slot
		logic strobe;     // present result
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  used;      // probed hash slot is occupied
		logic  match;     // stored pair equals the input pair
		logic  wrapped;   // every hash slot has been probed
		logic  clr_last;  // clearing pass at its last slot
		logic  full;      // ordered table is full
	} sts_t;
endpackage
`default_nettype wire

// ===== sv/edge_hit_count_table.sv =====
// Top level of the edge hit count table: controller and datapath.
// Depends on ehct_pkg, ehct_ctrl and ehct_dpath.
//
// Channel  Direction  Handshake          Word
// command  in         start while !busy  func, src_addr, dst_addr, read_slot
// result   out        done, one cycle    edge_from, edge_to, hit_count, entry_slot,
//                                        stored_entries, was_new, dropped, slot_valid
//
// A record word ends on a free hash slot (an insert, or a drop because the table is
// full) or on an occupied one (a hit, or a drop after every slot was probed). Each
// probe reads the hash memory, then the pair memory, then compares, all through single
// registered ports. A clear word walks the hash used bits one slot per cycle. After
// reset the same pass runs with busy high before the first word is taken, and gives
// no result.
// The receiver cannot stall: done is high for exactly one cycle per word.
`default_nettype none
module edge_hit_count_table #(
	parameter int unsigned ENTRIES     = ehct_pkg::ENTRIES_DEF,
	parameter int unsigned HASH_SLOTS  = ehct_pkg::HASH_SLOTS_DEF,
	parameter int unsigned COUNT_WIDTH = ehct_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] src_addr,
	input  wire logic [63:0] dst_addr,
	input  wire logic [9:0]  read_slot,
	output logic             done,
	output logic [63:0]      edge_from,
	output logic [63:0]      edge_to,
	output logic [31:0]      hit_count,
	output logic [9:0]       entry_slot,
	output logic [10:0]      stored_entries,
	output logic             was_new,
	output logic             dropped,
	output logic             slot_valid
);
	ehct_pkg::cmd_t cmd;
	ehct_pkg::sts_t sts;

	ehct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	ehct_dpath #(
		.ENTRIES(ENTRIES), .HASH_SLOTS(HASH_SLOTS), .COUNT_WIDTH(COUNT_WIDTH)
	) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .src_addr(src_addr), .dst_addr(dst_addr), .read_slot(read_slot),
		.strobe(done), .edge_from(edge_from), .edge_to(edge_to), .hit_count(hit_count),
		.entry_slot(entry_slot), .stored_entries(stored_entries), .was_new(was_new),
		.dropped(dropped), .slot_valid(slot_valid)
	);
endmodule
`default_nettype wire

// ===== sv/ehct_ctrl.sv =====
// Controller state machine of the edge hit count table.
// Depends on ehct_pkg.
`default_nettype none
module ehct_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire ehct_pkg::sts_t sts,
	output ehct_pkg::cmd_t      cmd
);
	ehct_pkg::state_t state_q, state_d;
	logic clr_done_q;

	// After reset the hash memory is cleared once before the first word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ehct_pkg::ST_CLEAR;
			clr_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ehct_pkg::ST_CLEAR && sts.clr_last) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ehct_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ehct_pkg::ST_HASH;
				end
			end
			ehct_pkg::ST_HASH: begin
				unique case (sts.func)
					ehct_pkg::FUNC_RECORD: state_d = ehct_pkg::ST_PROBE;
					ehct_pkg::FUNC_READ:   state_d = ehct_pkg::ST_READ;
					ehct_pkg::FUNC_CLEAR:  state_d = ehct_pkg::ST_CLEAR;
					default:               state_d = ehct_pkg::ST_DONE;
				endcase
			end
			ehct_pkg::ST_CLEAR: begin
				// The pass after reset has no word behind it and gives no result.
				if (sts.clr_last) begin
					state_d = clr_done_q ? ehct_pkg::ST_DONE : ehct_pkg::ST_IDLE;
				end
			end
			ehct_pkg::ST_PROBE:  state_d = ehct_pkg::ST_FETCH;
			ehct_pkg::ST_FETCH: begin
				if (sts.used) begin
					state_d = ehct_pkg::ST_PCMP;
				end else begin
					state_d = ehct_pkg::ST_INSERT;
				end
			end
			ehct_pkg::ST_PCMP: begin
				priority if (sts.match) begin
					state_d = ehct_pkg::ST_UPDATE;
				end else if (sts.wrapped) begin
					state_d = ehct_pkg::ST_INSERT;
				end else begin
					state_d = ehct_pkg::ST_PROBE;
				end
			end
			ehct_pkg::ST_UPDATE: state_d = ehct_pkg::ST_DONE;
			ehct_pkg::ST_INSERT: state_d = ehct_pkg::ST_DONE;
			ehct_pkg::ST_READ:   state_d = ehct_pkg::ST_RDOUT;
			ehct_pkg::ST_RDOUT:  state_d = ehct_pkg::ST_DONE;
			ehct_pkg::ST_DONE:   state_d = ehct_pkg::ST_IDLE;
			default:             state_d = ehct_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != ehct_pkg::ST_IDLE);
		unique case (state_q)
			ehct_pkg::ST_IDLE:   cmd.load = start;
			ehct_pkg::ST_HASH: begin
				cmd.hash     = 1'b1;
				cmd.do_misc  = (sts.func == ehct_pkg::FUNC_NONE);
			end
			ehct_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.do_misc  = sts.clr_last && clr_done_q;
			end
			ehct_pkg::ST_PROBE:  cmd.probe_rd = 1'b1;
			ehct_pkg::ST_FETCH:  cmd.entry_rd = sts.used;
			ehct_pkg::ST_PCMP:   cmd.step     = 1'b1;
			ehct_pkg::ST_UPDATE: cmd.do_hit = 1'b1;
			ehct_pkg::ST_INSERT: begin
				cmd.do_insert = !sts.used && !sts.full;
				cmd.do_drop   = sts.used || sts.full;
			end
			ehct_pkg::ST_READ:   cmd.slot_rd = 1'b1;
			ehct_pkg::ST_RDOUT:  cmd.do_read = 1'b1;
			ehct_pkg::ST_DONE:   cmd.strobe  = 1'b1;
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_busy_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ehct_pkg::ST_DONE |-> busy)
		else $error("busy low while a result is shown");
	a_idle_after_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.strobe |=> state_q == ehct_pkg::ST_IDLE)
		else $error("controller did not return to idle after a result");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy)
		else $error("word loaded while busy");
`endif
endmodule
`default_nettype wire

// ===== sv/ehct_dpath.sv =====
// Datapath of the edge hit count table: hash, hash and ordered memories,
// probe logic and result registers. Depends on ehct_pkg.
`default_nettype none
module ehct_dpath #(
	parameter int unsigned ENTRIES     = ehct_pkg::ENTRIES_DEF,
	parameter int unsigned HASH_SLOTS  = ehct_pkg::HASH_SLOTS_DEF,
	parameter int unsigned COUNT_WIDTH = ehct_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ehct_pkg::cmd_t              cmd,
	output ehct_pkg::sts_t                   sts,
	input  wire logic [1:0]                  func,
	input  wire logic [ehct_pkg::ADDR_W-1:0] src_addr,
	input  wire logic [ehct_pkg::ADDR_W-1:0] dst_addr,
	input  wire logic [9:0]                  read_slot,
	output logic                             strobe,
	output logic [ehct_pkg::ADDR_W-1:0]      edge_from,
	output logic [ehct_pkg::ADDR_W-1:0]      edge_to,
	output logic [31:0]                      hit_count,
	output logic [9:0]                       entry_slot,
	output logic [10:0]                      stored_entries,
	output logic                             was_new,
	output logic                             dropped,
	output logic                             slot_valid
);
	localparam int unsigned SW = $clog2(ENTRIES);
	localparam int unsigned HW = $clog2(HASH_SLOTS);
	localparam int unsigned TW = $clog2(ENTRIES + 1);
	localparam int unsigned AW = ehct_pkg::ADDR_W;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [2*AW-1:0]        pair_mem [ENTRIES];
	logic [COUNT_WIDTH-1:0] cnt_mem  [ENTRIES];
	logic                   used_mem [HASH_SLOTS];
	logic [SW-1:0]          ptr_mem  [HASH_SLOTS];

	ehct_pkg::func_t func_q;
	logic [AW-1:0]   src_q, dst_q;
	logic [9:0]      rslot_q;
	logic [TW-1:0]   total_q;
	logic [HW-1:0]   pos_q, free_q;
	logic [HW:0]     nprobe_q;
	logic            used_q;
	logic [SW-1:0]   ptr_q;
	logic [2*AW-1:0] pair_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [HW-1:0]   clr_q;
	logic            any_free_q;

	logic [HW-1:0]   hash_pos;
	logic            ptr_ok, slot_ok;

	// Simple fold hash; any spread works since results do not depend on it.
	// The low bits are folded once more so the start lies below HASH_SLOTS.
	always_comb begin
		logic [AW-1:0] h;
		logic [HW-1:0] hl;
		h = src_q ^ {dst_q[AW-14:0], dst_q[AW-1:AW-13]} ^ (src_q >> 17) ^ (dst_q >> 31);
		h = h ^ (h >> 23) ^ (h >> 41);
		hl = h[HW-1:0];
		hash_pos = (32'(hl) >= HASH_SLOTS) ? hl - HW'(HASH_SLOTS) : hl;
	end

	assign ptr_ok  = ({{(TW-SW){1'b0}}, ptr_q} < total_q);
	assign slot_ok = (32'(rslot_q) < 32'(total_q)) && (32'(rslot_q) < ENTRIES);

	always_comb begin
		sts          = '0;
		sts.func     = func_q;
		sts.used     = used_q;
		sts.match    = used_q && ptr_ok && (pair_q == {src_q, dst_q});
		sts.wrapped  = (nprobe_q >= (HW+1)'(HASH_SLOTS - 1));
		sts.clr_last = (clr_q == HW'(HASH_SLOTS - 1));
		sts.full     = (total_q >= TW'(ENTRIES));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q   <= src_addr;
			dst_q   <= dst_addr;
			rslot_q <= read_slot;
		end
		if (cmd.hash) begin
			pos_q    <= hash_pos;
			nprobe_q <= '0;
		end
		if (cmd.probe_rd) begin
			used_q <= used_mem[pos_q];
			ptr_q  <= ptr_mem[pos_q];
			free_q <= pos_q;
		end
		if (cmd.entry_rd || cmd.slot_rd) begin
			pair_q <= pair_mem[cmd.slot_rd ? SW'(rslot_q) : ptr_q];
			cnt_q  <= cnt_mem[cmd.slot_rd ? SW'(rslot_q) : ptr_q];
		end
		if (cmd.step) begin
			pos_q    <= (pos_q == HW'(HASH_SLOTS - 1)) ? '0 : pos_q + 1'b1;
			nprobe_q <= nprobe_q + 1'b1;
		end
		if (cmd.do_hit && cnt_q != CMAX) begin
			cnt_mem[ptr_q] <= cnt_q + 1'b1;
		end
		if (cmd.do_insert) begin
			pair_mem[total_q[SW-1:0]] <= {src_q, dst_q};
			cnt_mem[total_q[SW-1:0]]  <= COUNT_WIDTH'(1);
			ptr_mem[free_q]           <= total_q[SW-1:0];
		end
	end

	// Hash used bits: written by insert and by the clearing pass.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			used_mem[clr_q] <= 1'b0;
		end else if (cmd.do_insert) begin
			used_mem[free_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q     <= ehct_pkg::FUNC_NONE;
			total_q    <= '0;
			clr_q      <= '0;
			strobe     <= 1'b0;
			any_free_q <= 1'b0;
		end else begin
			strobe <= cmd.strobe;
			if (cmd.load) begin
				func_q <= ehct_pkg::func_t'(func);
			end
			if (cmd.clr_step) begin
				clr_q <= sts.clr_last ? '0 : clr_q + 1'b1;
				total_q <= '0;
			end
			if (cmd.do_insert) begin
				total_q <= total_q + 1'b1;
			end
			any_free_q <= cmd.do_insert;
		end
	end

	always_ff @(posedge clk) begin
		logic [COUNT_WIDTH-1:0] nc;
		nc = (cnt_q == CMAX) ? cnt_q : cnt_q + 1'b1;
		if (cmd.hash || cmd.do_misc) begin
			edge_from      <= '0;
			edge_to        <= '0;
			hit_count      <= '0;
			entry_slot     <= '0;
			stored_entries <= 11'(total_q);
			was_new        <= 1'b0;
			dropped        <= 1'b0;
			slot_valid     <= 1'b0;
		end
		if (cmd.clr_step) begin
			stored_entries <= '0;
		end
		if (cmd.do_hit) begin
			edge_from  <= src_q;
			edge_to    <= dst_q;
			hit_count  <= 32'(nc);
			entry_slot <= 10'(ptr_q);
		end
		if (cmd.do_insert) begin
			edge_from      <= src_q;
			edge_to        <= dst_q;
			hit_count      <= 32'd1;
			entry_slot     <= 10'(total_q);
			stored_entries <= 11'(total_q + 1'b1);
			was_new        <= 1'b1;
		end
		if (cmd.do_drop) begin
			edge_from <= src_q;
			edge_to   <= dst_q;
			dropped   <= 1'b1;
		end
		if (cmd.do_read && slot_ok) begin
			edge_from  <= pair_q[2*AW-1:AW];
			edge_to    <= pair_q[AW-1:0];
			hit_count  <= 32'(cnt_q);
			slot_valid <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(ENTRIES))
		else $error("edge total above table size");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |=> total_q == $past(total_q) + 1'b1)
		else $error("insert did not grow the total");
	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_insert |-> !used_q && !sts.full)
		else $error("insert into an occupied slot or full table");
	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(was_new && dropped) && !(slot_valid && (was_new || dropped)))
		else $error("conflicting result flags");
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		any_free_q |-> total_q != '0)
		else $error("total zero after insert");
`endif
endmodule
`default_nettype wire
